// ----- design/chts_pkg.sv -----
// Shared types, constants and the bucket hash for the chained hash symbol table.
`default_nettype none
package chts_pkg;

  // Table geometry. The bucket count is a power of two.
  localparam int BUCKET_COUNT = 16;
  localparam int POOL_ENTRIES = 64;
  localparam int KEY_WIDTH    = 32;
  localparam int VALUE_WIDTH  = 32;

  // Bucket index, pool index and pool pointer widths.
  // A pointer has one more code than the pool: the empty-chain marker.
  localparam int BKT_W = $clog2(BUCKET_COUNT);
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int PTR_W = $clog2(POOL_ENTRIES + 1);

  // Hash shift amounts.
  localparam int HASH_SHIFT_LO = 3;
  localparam int HASH_SHIFT_HI = 10;

  typedef logic [BKT_W-1:0]       bkt_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam ptr_t NIL_PTR = PTR_W'(POOL_ENTRIES);

  // Action codes.
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_LOCAL  = 3'd1;
  localparam logic [2:0] ACT_WEAK   = 3'd2;
  localparam logic [2:0] ACT_GET    = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Write command towards the entry pool.
  typedef struct packed {
    logic   all_en;
    logic   val_en;
    idx_t   addr;
    key_t   key;
    value_t value;
    ptr_t   next;
    logic   weak_mark;
  } pool_wr_t;

  // Command towards the bucket head registers.
  typedef struct packed {
    logic clear;
    logic wr_en;
    bkt_t idx;
    ptr_t ptr;
  } bkt_cmd_t;

  // Bucket of a key: ((key >> 3) xor (key >> 10)) mod BUCKET_COUNT.
  function automatic bkt_t bucket_of(key_t k);
    key_t mixed;
    mixed = (k >> HASH_SHIFT_LO) ^ (k >> HASH_SHIFT_HI);
    return mixed[BKT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/chts_bucket.sv -----
// Bucket head registers that clear all heads at once, with one hashed read port.
`default_nettype none
module chts_bucket (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire chts_pkg::bkt_cmd_t cmd,
  input  wire chts_pkg::key_t     rd_key,
  output chts_pkg::ptr_t          rd_head
);

  chts_pkg::ptr_t head_r [chts_pkg::BUCKET_COUNT];

  // Heads reset and clear to the empty-chain marker.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int b = 0; b < chts_pkg::BUCKET_COUNT; b++) begin
        head_r[b] <= chts_pkg::NIL_PTR;
      end
    end else if (cmd.wr_en) begin
      head_r[cmd.idx] <= cmd.ptr;
    end
  end

  // Head of the bucket that the presented key hashes to.
  assign rd_head = head_r[chts_pkg::bucket_of(rd_key)];

endmodule
`default_nettype wire

// ----- design/chts_pool.sv -----
// Entry pool memory: key, value, next pointer and weak mark, registered read.
`default_nettype none
module chts_pool (
  input  wire logic               clk,
  input  wire chts_pkg::pool_wr_t wr,
  input  wire chts_pkg::idx_t     rd_addr,
  output chts_pkg::key_t          rd_key,
  output chts_pkg::value_t        rd_value,
  output chts_pkg::ptr_t          rd_next,
  output logic                    rd_weak
);

  chts_pkg::key_t   key_mem   [chts_pkg::POOL_ENTRIES];
  chts_pkg::value_t value_mem [chts_pkg::POOL_ENTRIES];
  chts_pkg::ptr_t   next_mem  [chts_pkg::POOL_ENTRIES];
  logic             weak_mem  [chts_pkg::POOL_ENTRIES];

  // A full entry write for a new key; a value-only write for a local overwrite.
  always_ff @(posedge clk) begin
    if (wr.all_en) begin
      key_mem[wr.addr]  <= wr.key;
      next_mem[wr.addr] <= wr.next;
      weak_mem[wr.addr] <= wr.weak_mark;
    end
    if (wr.all_en || wr.val_en) begin
      value_mem[wr.addr] <= wr.value;
    end
  end

  // Registered read of one entry.
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
    rd_next  <= next_mem[rd_addr];
    rd_weak  <= weak_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- design/chained_hash_symbol_table.sv -----
// Top level of the chained hash symbol table: sequencer, chain walk and result register.
//
//   Channel  Ports                                        Direction  Handshake
//   in       in_action, in_key, in_value                  input      in_valid / in_stall
//   out      out_status, out_found_value, out_found_weak  output     out_valid / out_stall
//   cfg      cfg_wdata (undefined marker)                 input      cfg_we, no wait
//
// One transaction at a time. Clear and unknown actions go from acceptance straight to the
// result; a lookup visits chain entries in ISSUE/CMP pairs until the key is found, and a
// walk that reaches the chain end needs an ISSUE step of its own for the end-of-chain
// check, in which a new entry is linked. Each entry costs a pool read (ISSUE) and a key
// compare (CMP) on the single pool read port.
// Reset empties every bucket and zeroes the pool fill count; the pool needs no clearing.
// in_stall stays high from acceptance until the result has been taken.
`default_nettype none
module chained_hash_symbol_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_value,
  output logic             out_found_weak,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         act_r, act_nxt;
  chts_pkg::key_t     key_r, key_nxt;
  chts_pkg::value_t   val_r, val_nxt;
  chts_pkg::bkt_t     bkt_r, bkt_nxt;
  chts_pkg::ptr_t     head_r, head_nxt;
  chts_pkg::ptr_t     ptr_r, ptr_nxt;
  chts_pkg::ptr_t     used_r, used_nxt;
  chts_pkg::value_t   marker_r;
  logic [1:0]         status_r, status_nxt;
  chts_pkg::value_t   fval_r, fval_nxt;
  logic               fweak_r, fweak_nxt;

  chts_pkg::bkt_cmd_t bkt_cmd;
  chts_pkg::ptr_t     rd_head;
  chts_pkg::pool_wr_t pool_wr;
  chts_pkg::key_t     rd_key;
  chts_pkg::value_t   rd_value;
  chts_pkg::ptr_t     rd_next;
  logic               rd_weak;
  logic               in_acc;
  chts_pkg::key_t     in_key_m;

  assign in_key_m = in_key[chts_pkg::KEY_WIDTH-1:0];
  assign in_acc   = in_valid && !in_stall;

  chts_bucket u_bucket (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (bkt_cmd),
    .rd_key  (in_key_m),
    .rd_head (rd_head)
  );

  chts_pool u_pool (
    .clk      (clk),
    .wr       (pool_wr),
    .rd_addr  (ptr_r[chts_pkg::IDX_W-1:0]),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .rd_next  (rd_next),
    .rd_weak  (rd_weak)
  );

  // Sequencer: accept, walk the chain one entry per read/compare pair, then present.
  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    bkt_nxt    = bkt_r;
    head_nxt   = head_r;
    ptr_nxt    = ptr_r;
    used_nxt   = used_r;
    status_nxt = status_r;
    fval_nxt   = fval_r;
    fweak_nxt  = fweak_r;

    bkt_cmd.clear = 1'b0;
    bkt_cmd.wr_en = 1'b0;
    bkt_cmd.idx   = bkt_r;
    bkt_cmd.ptr   = used_r;

    pool_wr.all_en    = 1'b0;
    pool_wr.val_en    = 1'b0;
    pool_wr.addr      = used_r[chts_pkg::IDX_W-1:0];
    pool_wr.key       = key_r;
    pool_wr.value     = val_r;
    pool_wr.next      = head_r;
    pool_wr.weak_mark = (act_r == chts_pkg::ACT_WEAK);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt   = in_action;
          key_nxt   = in_key_m;
          val_nxt   = in_value;
          bkt_nxt   = chts_pkg::bucket_of(in_key_m);
          head_nxt  = rd_head;
          ptr_nxt   = rd_head;
          fval_nxt  = '0;
          fweak_nxt = 1'b0;
          case (in_action)
            chts_pkg::ACT_INSERT, chts_pkg::ACT_LOCAL,
            chts_pkg::ACT_WEAK, chts_pkg::ACT_GET: begin
              state_nxt = ST_ISSUE;
            end
            chts_pkg::ACT_CLEAR: begin
              bkt_cmd.clear = 1'b1;
              used_nxt      = '0;
              status_nxt    = chts_pkg::STAT_OK;
              state_nxt     = ST_OUT;
            end
            default: begin
              status_nxt = chts_pkg::STAT_MISS;
              state_nxt  = ST_OUT;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        if (ptr_r == chts_pkg::NIL_PTR) begin
          // End of chain: the key is absent.
          state_nxt = ST_OUT;
          if (act_r == chts_pkg::ACT_GET) begin
            status_nxt = chts_pkg::STAT_MISS;
          end else if (used_r == chts_pkg::NIL_PTR) begin
            status_nxt = chts_pkg::STAT_FULL;
          end else begin
            // Link a new entry at the head of its chain.
            pool_wr.all_en = 1'b1;
            bkt_cmd.wr_en  = 1'b1;
            used_nxt       = used_r + chts_pkg::ptr_t'(1);
            status_nxt     = chts_pkg::STAT_OK;
          end
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rd_key == key_r) begin
          state_nxt = ST_OUT;
          if (act_r == chts_pkg::ACT_GET) begin
            fval_nxt   = rd_value;
            fweak_nxt  = rd_weak;
            status_nxt = chts_pkg::STAT_OK;
          end else if (act_r == chts_pkg::ACT_LOCAL && rd_value == marker_r) begin
            // Local insert replaces an undefined value and keeps the weak mark.
            pool_wr.val_en = 1'b1;
            pool_wr.addr   = ptr_r[chts_pkg::IDX_W-1:0];
            status_nxt     = chts_pkg::STAT_OK;
          end else begin
            status_nxt = chts_pkg::STAT_MISS;
          end
        end else begin
          ptr_nxt   = rd_next;
          state_nxt = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      used_r   <= '0;
      marker_r <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (cfg_we) begin
        marker_r <= cfg_wdata;
      end
    end
  end

  // Transaction payload and result registers.
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    bkt_r    <= bkt_nxt;
    head_r   <= head_nxt;
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    fval_r   <= fval_nxt;
    fweak_r  <= fweak_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_status      = status_r;
  assign out_found_value = fval_r;
  assign out_found_weak  = fweak_r;

  // An accepted transaction blocks the input until its result is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after acceptance");

  // A result is never offered while the input is open.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result offered while accepting input");

  // The pool fill count never passes the pool size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= chts_pkg::NIL_PTR)
    else $error("pool fill count out of range");

  // Found data is only reported with a successful status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != chts_pkg::STAT_OK |-> out_found_value == '0 && !out_found_weak)
    else $error("found data with a failing status");

endmodule
`default_nettype wire

// ----- tb/chts_checker.sv -----
// Checker for the chained hash symbol table: shadow table, expected replies and comparison.
`timescale 1ns / 1ps
module chts_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_value,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  out_status,
  input  wire logic [31:0] out_found_value,
  input  wire logic        out_found_weak,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count,
  output int               results_checked,
  output int               full_replies
);

  typedef struct packed {
    logic [1:0]       status;
    chts_pkg::value_t found_value;
    logic             found_weak;
  } table_reply_t;

  // Shadow copy of the table and the undefined marker.
  chts_pkg::ptr_t   head_ptr   [chts_pkg::BUCKET_COUNT];
  chts_pkg::key_t   slot_key   [chts_pkg::POOL_ENTRIES];
  chts_pkg::value_t slot_value [chts_pkg::POOL_ENTRIES];
  chts_pkg::ptr_t   slot_next  [chts_pkg::POOL_ENTRIES];
  logic             slot_weak  [chts_pkg::POOL_ENTRIES];
  int               slots_taken;
  chts_pkg::value_t marker;

  // Replies owed by the block, oldest first.
  table_reply_t owed_replies[$];

  // Walks one chain and returns the slot holding the key, or the empty marker.
  function automatic chts_pkg::ptr_t locate_key(chts_pkg::bkt_t b, chts_pkg::key_t k);
    chts_pkg::ptr_t p;
    int             steps;
    p = head_ptr[b];
    steps = 0;
    while (p < chts_pkg::NIL_PTR && steps < chts_pkg::POOL_ENTRIES) begin
      if (slot_key[p[chts_pkg::IDX_W-1:0]] == k) return p;
      p = slot_next[p[chts_pkg::IDX_W-1:0]];
      steps++;
    end
    return chts_pkg::NIL_PTR;
  endfunction

  // Applies one transaction to the shadow table and returns the reply it should give.
  function automatic table_reply_t apply_table_action(logic [2:0] act, chts_pkg::key_t k,
                                                      chts_pkg::value_t v);
    table_reply_t   r;
    chts_pkg::bkt_t b;
    chts_pkg::ptr_t hit;
    chts_pkg::idx_t slot;
    r = '0;
    r.status = chts_pkg::STAT_OK;
    b = chts_pkg::bkt_t'((k >> chts_pkg::HASH_SHIFT_LO) ^ (k >> chts_pkg::HASH_SHIFT_HI));
    case (act)
      chts_pkg::ACT_INSERT, chts_pkg::ACT_LOCAL, chts_pkg::ACT_WEAK: begin
        hit = locate_key(b, k);
        if (hit < chts_pkg::NIL_PTR) begin
          // A local insert may only replace a value equal to the marker.
          if (act == chts_pkg::ACT_LOCAL &&
              slot_value[hit[chts_pkg::IDX_W-1:0]] == marker) begin
            slot_value[hit[chts_pkg::IDX_W-1:0]] = v;
          end else begin
            r.status = chts_pkg::STAT_MISS;
          end
        end else if (slots_taken >= chts_pkg::POOL_ENTRIES) begin
          r.status = chts_pkg::STAT_FULL;
        end else begin
          slot = chts_pkg::idx_t'(slots_taken);
          slot_key[slot]   = k;
          slot_value[slot] = v;
          slot_weak[slot]  = (act == chts_pkg::ACT_WEAK);
          slot_next[slot]  = head_ptr[b];
          head_ptr[b]      = chts_pkg::ptr_t'(slots_taken);
          slots_taken++;
        end
      end
      chts_pkg::ACT_GET: begin
        hit = locate_key(b, k);
        if (hit < chts_pkg::NIL_PTR) begin
          r.found_value = slot_value[hit[chts_pkg::IDX_W-1:0]];
          r.found_weak  = slot_weak[hit[chts_pkg::IDX_W-1:0]];
        end else begin
          r.status = chts_pkg::STAT_MISS;
        end
      end
      chts_pkg::ACT_CLEAR: begin
        foreach (head_ptr[i]) head_ptr[i] = chts_pkg::NIL_PTR;
        slots_taken = 0;
      end
      default: begin
        r.status = chts_pkg::STAT_MISS;
      end
    endcase
    return r;
  endfunction

  // Counts a failure and reports the first few of them.
  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Results are checked before the input side so that the queue order is kept.
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      foreach (head_ptr[i]) head_ptr[i] = chts_pkg::NIL_PTR;
      slots_taken = 0;
      marker = '0;
      owed_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_replies.size() == 0) begin
          note_failure($sformatf("result with nothing owed: status %0d value %h weak %0b",
                                 out_status, out_found_value, out_found_weak));
        end else begin
          want = owed_replies.pop_front();
          results_checked++;
          if (out_status !== want.status || out_found_value !== want.found_value ||
              out_found_weak !== want.found_weak) begin
            note_failure($sformatf({"result %0d: status exp %0d got %0d, ",
                                    "value exp %h got %h, weak exp %0b got %0b"},
                                   results_checked, want.status, out_status,
                                   want.found_value, out_found_value,
                                   want.found_weak, out_found_weak));
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_table_action(in_action, in_key, in_value);
        if (want.status == chts_pkg::STAT_FULL) full_replies++;
        owed_replies.push_back(want);
      end
      if (cfg_we) marker = cfg_wdata;
    end
    pending_count <= owed_replies.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the chained hash symbol table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  // Action codes with no operation behind them.
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOT_KEYS        = 24;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [31:0] in_key    = '0;
  logic [31:0] in_value  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_found_value;
  logic        out_found_weak;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int               fail_count;
  int               pending_count;
  int               results_checked;
  int               full_replies;
  int               burst_left = 0;
  int               stall_tick = 0;
  int               marker_settings = 0;
  int               sent_by_action [8];
  chts_pkg::key_t   hot_keys [HOT_KEYS];
  chts_pkg::value_t marker_now = '0;

  chained_hash_symbol_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_found_weak  (out_found_weak),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  chts_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_found_weak  (out_found_weak),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .full_replies    (full_replies)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stall pattern: free-running, then light, heavy and long regular stalls.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick / 300) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3, 0) == 0);
      2: out_stall <= ($urandom_range(9, 0) < 7);
      default: out_stall <= stall_tick[4];
    endcase
  end

  // Offers one transaction and waits for it to be taken; bursts are separated by gaps.
  task automatic send_item(logic [2:0] act, chts_pkg::key_t k, chts_pkg::value_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_action <= act;
    in_key    <= k;
    in_value  <= v;
    do @(posedge clk); while (in_stall);
    sent_by_action[act]++;
  endtask

  // Holds the sender back until every owed result has been taken.
  task automatic settle_table();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Writes the undefined marker while the block is idle.
  task automatic set_marker(chts_pkg::value_t m);
    settle_table();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    marker_now = m;
    marker_settings++;
  endtask

  // Half the hot keys hash to bucket zero so that long chains build up.
  task automatic refresh_hot_keys();
    foreach (hot_keys[i]) begin
      hot_keys[i] = $urandom();
      if (i % 2 == 0) hot_keys[i] = hot_keys[i] & ~32'h0000_3C78;
    end
  endtask

  // One random transaction; fill mode has no clears and mostly inserts.
  task automatic random_item(bit fill_mode);
    int               roll;
    logic [2:0]       act;
    chts_pkg::key_t   k;
    chts_pkg::value_t v;
    roll = $urandom_range(99, 0);
    if (fill_mode) roll = roll % 80;
    if (roll < 30) act = chts_pkg::ACT_INSERT;
    else if (roll < 45) act = chts_pkg::ACT_LOCAL;
    else if (roll < 55) act = chts_pkg::ACT_WEAK;
    else if (roll < 92) act = chts_pkg::ACT_GET;
    else if (roll < 95) act = chts_pkg::ACT_CLEAR;
    else act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    if ($urandom_range(9, 0) < (fill_mode ? 4 : 7)) begin
      k = hot_keys[$urandom_range(HOT_KEYS - 1, 0)];
    end else begin
      k = $urandom();
    end
    v = ($urandom_range(3, 0) == 0) ? marker_now : chts_pkg::value_t'($urandom());
    send_item(act, k, v);
  endtask

  // Main stimulus.
  initial begin
    chts_pkg::value_t phase_marker;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed transactions with the marker at its reset value of zero.
    send_item(chts_pkg::ACT_GET,    32'h0000_0000, 32'h0000_0000);
    send_item(chts_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_item(chts_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0005);
    send_item(chts_pkg::ACT_LOCAL,  32'h0000_0000, 32'hFFFF_FFFF);
    send_item(chts_pkg::ACT_LOCAL,  32'h0000_0000, 32'h0000_0007);
    send_item(chts_pkg::ACT_GET,    32'h0000_0000, 32'h0000_0000);
    send_item(chts_pkg::ACT_WEAK,   32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_item(chts_pkg::ACT_GET,    32'hFFFF_FFFF, 32'h0000_0000);
    send_item(chts_pkg::ACT_WEAK,   32'hFFFF_FFFF, 32'h0000_0001);
    send_item(chts_pkg::ACT_INSERT, 32'h0000_0080, 32'h1234_5678);
    send_item(chts_pkg::ACT_WEAK,   32'h0001_0000, 32'h0000_0000);
    send_item(chts_pkg::ACT_GET,    32'h0000_0000, 32'h0000_0000);
    send_item(chts_pkg::ACT_GET,    32'h0001_0000, 32'h0000_0000);
    send_item(chts_pkg::ACT_GET,    32'h0000_0008, 32'h0000_0000);
    send_item(ACT_SPARE_LO,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_SPARE_LO + 1, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_SPARE_HI,     32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_item(chts_pkg::ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(chts_pkg::ACT_GET,    32'h0000_0000, 32'h0000_0000);
    send_item(chts_pkg::ACT_LOCAL,  32'h55AA_55AA, 32'h0000_0000);
    send_item(chts_pkg::ACT_GET,    32'h55AA_55AA, 32'h0000_0000);

    // Random phases, each under its own marker; phases one and four fill the pool.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 5:    phase_marker = 32'h0000_0000;
        1, 4:    phase_marker = 32'hFFFF_FFFF;
        default: phase_marker = $urandom();
      endcase
      set_marker(phase_marker);
      refresh_hot_keys();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item(p == 1 || p == 4);
    end

    settle_table();
    repeat (20) @(posedge clk);
    $display("Covered %0d insert, %0d local insert, %0d weak insert, %0d get, %0d clear",
             sent_by_action[chts_pkg::ACT_INSERT], sent_by_action[chts_pkg::ACT_LOCAL],
             sent_by_action[chts_pkg::ACT_WEAK], sent_by_action[chts_pkg::ACT_GET],
             sent_by_action[chts_pkg::ACT_CLEAR]);
    $display("and %0d spare-code transactions; %0d results checked, %0d pool-full, %0d markers.",
             sent_by_action[5] + sent_by_action[6] + sent_by_action[7], results_checked,
             full_replies, marker_settings);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4_000_000;
    $display("Run limit reached with %0d results still owed.", pending_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule
